@@ rtl/core/cas_pkg.sv @@
// Package for the compacting array store: operation, status and sequencer state types.
// It depends on nothing and is used by rtl/core/compacting_array_store.sv.
package cas_pkg;

  // Operation codes carried on in_func.
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_DELETE = 2'd3
  } func_t;

  // Status codes reported on out_status.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHIFT = 2'd1,
    ST_RESP  = 2'd2
  } state_t;

endpackage

@@ rtl/core/compacting_array_store.sv @@
// Compacting array store: a dense array of signed words in one synchronous memory
// with a fill count. Depends on rtl/core/cas_pkg.sv.
//
// Usage. A request is accepted on a rising edge where start is high and busy is
// low; it carries an operation (in_func), an entry position (in_index) and a word
// (in_value). Append writes the word at the end of the array, set overwrites an
// entry below the fill count, get reads one and delete removes one, moving every
// later entry down by one place. Each request gives exactly one result word on
// out_read_value, out_fill_count and out_status, shown for exactly one cycle while
// out_valid is high; the receiver cannot stall, so it must take the word then.
// Append, set and get go from acceptance to the result state, and a new request
// is accepted only once the result cycle has ended. A successful delete that
// leaves entries above the removed one passes through the shift state first,
// as the single memory port pair moves one word per cycle (read one place up,
// write it back one place down). busy is high from the cycle after acceptance
// until the result cycle has ended. At reset the fill count clears to zero and
// the sequencer returns to idle; the memory contents are not cleared, as no
// entry at or above the fill count is ever used.
module compacting_array_store #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic [$clog2(DEPTH)-1:0]          in_index,
  input  logic signed [31:0]                in_value,
  output logic                              out_valid,
  output logic signed [31:0]                out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]        out_fill_count,
  output logic [1:0]                        out_status
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer and bookkeeping registers.
  cas_pkg::state_t  state_r, state_nxt;
  cas_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;   // address whose word sits in rd_q while shifting
  logic             hit_r, hit_nxt;   // the pending result is a successful get

  // Memory and its port controls.
  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [IDX_W-1:0] rd_addr;

  logic             accept;
  logic             full;
  logic             in_range;
  logic             more_shift;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] ptr_ext;

  assign accept     = start && !busy;
  assign full       = (count_r == CNT_W'(DEPTH));
  assign idx_ext    = CNT_W'(in_index);
  assign ptr_ext    = CNT_W'(ptr_r);
  assign in_range   = (idx_ext < count_r);
  // While shifting, another word has to move if the next place up is still in use.
  assign more_shift = ((ptr_ext + CNT_W'(1)) < count_r);

  // The memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cas_pkg::ST_IDLE: begin
        if (accept) begin
          // A delete that leaves entries above the removed one goes through the shift loop.
          if ((cas_pkg::func_t'(in_func) == cas_pkg::FUNC_DELETE) && in_range &&
              ((idx_ext + CNT_W'(1)) < count_r)) begin
            state_nxt = cas_pkg::ST_SHIFT;
          end else begin
            state_nxt = cas_pkg::ST_RESP;
          end
        end
      end
      cas_pkg::ST_SHIFT: begin
        if (!more_shift) begin
          state_nxt = cas_pkg::ST_RESP;
        end
      end
      cas_pkg::ST_RESP: begin
        state_nxt = cas_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cas_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy      = (state_r != cas_pkg::ST_IDLE);
    out_valid = (state_r == cas_pkg::ST_RESP);
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_q;
    rd_addr   = ptr_r;
    unique case (state_r)
      cas_pkg::ST_IDLE: begin
        if (cas_pkg::func_t'(in_func) == cas_pkg::FUNC_GET) begin
          rd_addr = in_index;
        end else begin
          rd_addr = IDX_W'(in_index + 1'b1);
        end
        if (accept) begin
          unique case (cas_pkg::func_t'(in_func))
            cas_pkg::FUNC_APPEND: begin
              wr_en   = !full;
              wr_addr = count_r[IDX_W-1:0];
              wr_data = in_value;
            end
            cas_pkg::FUNC_SET: begin
              wr_en   = in_range;
              wr_addr = in_index;
              wr_data = in_value;
            end
            cas_pkg::FUNC_GET,
            cas_pkg::FUNC_DELETE: begin
              wr_en = 1'b0;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
      end
      cas_pkg::ST_SHIFT: begin
        // Move the word one place down and fetch the next one up.
        wr_en   = 1'b1;
        wr_addr = IDX_W'(ptr_r - 1'b1);
        wr_data = rd_q;
        rd_addr = IDX_W'(ptr_r + 1'b1);
      end
      cas_pkg::ST_RESP: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Bookkeeping: fill count, shift pointer and the pending result's status.
  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    if (accept) begin
      status_nxt = cas_pkg::STAT_DONE;
      hit_nxt    = 1'b0;
      ptr_nxt    = IDX_W'(in_index + 1'b1);
      case (cas_pkg::func_t'(in_func))
        cas_pkg::FUNC_APPEND: begin
          if (full) begin
            status_nxt = cas_pkg::STAT_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        cas_pkg::FUNC_SET: begin
          if (!in_range) begin
            status_nxt = cas_pkg::STAT_RANGE;
          end
        end
        cas_pkg::FUNC_GET: begin
          if (!in_range) begin
            status_nxt = cas_pkg::STAT_RANGE;
          end else begin
            hit_nxt = 1'b1;
          end
        end
        cas_pkg::FUNC_DELETE: begin
          if (!in_range) begin
            status_nxt = cas_pkg::STAT_RANGE;
          end else if ((idx_ext + CNT_W'(1)) >= count_r) begin
            // Removing the top entry needs no move.
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = cas_pkg::STAT_DONE;
        end
      endcase
    end else if (state_r == cas_pkg::ST_SHIFT) begin
      ptr_nxt = IDX_W'(ptr_r + 1'b1);
      if (!more_shift) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cas_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
  end

  // The read data register holds the fetched entry during the result cycle of a get.
  assign out_read_value = hit_r ? rd_q : '0;
  assign out_fill_count = count_r;
  assign out_status     = status_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  // An accepted request holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  // A full status is only reported when the store really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status_r == cas_pkg::STAT_FULL)) |-> full)
    else $error("full status with room left");

  // Each result word lasts a single cycle and is followed by idle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe repeated");

  // A result with a read word comes only from a successful get.
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && hit_r) |-> (status_r == cas_pkg::STAT_DONE))
    else $error("read word with a failing status");

endmodule
